>>> rtl/bounded_deque_with_middle_core_defines.svh
// Assertion macros for the bounded deque core.
// Used by the top level only; has no dependencies of its own.
`ifndef BOUNDED_DEQUE_WITH_MIDDLE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_MIDDLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define BDM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");
// Next-cycle implication, disabled while reset is high.
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");
`else
`define BDM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/bdm_pkg.sv
// Shared types and constants for the bounded deque core.
// No dependencies; imported by the cell, the cell row and the top level.
package bdm_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_MID  = 1'b1
   } fsm_type;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic             shift_right;
      logic             shift_left;
      logic             write_back;
      logic [IDX_W-1:0] back_idx;
      logic [IDX_W-1:0] sel_idx;
   } cell_ctrl_type;

endpackage

>>> rtl/bdm_cell.sv
// One storage cell of the deque chain: holds one word and trades it with neighbors.
// Depends on bdm_pkg.
module bdm_cell (
   input  logic                        clock,
   input  logic [bdm_pkg::IDX_W-1:0]   index,
   input  bdm_pkg::cell_ctrl_type      ctrl,
   input  logic [bdm_pkg::DATA_W-1:0]  value,
   input  logic [bdm_pkg::DATA_W-1:0]  left_data,
   input  logic [bdm_pkg::DATA_W-1:0]  right_data,
   output logic [bdm_pkg::DATA_W-1:0]  data,
   output logic [bdm_pkg::DATA_W-1:0]  tap
);
   import bdm_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      priority if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.write_back && (index == ctrl.back_idx)) begin
         data_in = value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // Only the selected cell drives its word onto the shared tap bus.
   assign tap  = (index == ctrl.sel_idx) ? data_ff : '0;

endmodule

>>> rtl/bdm_cell_row.sv
// Row of deque cells, front at cell zero, with the OR-combined tap bus.
// Depends on bdm_pkg and bdm_cell.
module bdm_cell_row (
   input  logic                        clock,
   input  bdm_pkg::cell_ctrl_type      ctrl,
   input  logic [bdm_pkg::DATA_W-1:0]  value,
   output logic [bdm_pkg::DATA_W-1:0]  tap_data
);
   import bdm_pkg::*;

   logic [DATA_W-1:0] data_w [DEPTH];
   logic [DATA_W-1:0] tap_w  [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      // The new front word enters at cell zero; the last cell refills with itself.
      if (g == 0) begin : g_first
         assign left_w = value;
      end else begin : g_inner_left
         assign left_w = data_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = data_w[g];
      end else begin : g_inner_right
         assign right_w = data_w[g+1];
      end

      bdm_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(g)),
         .ctrl       (ctrl),
         .value      (value),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (data_w[g]),
         .tap        (tap_w[g])
      );
   end

   always_comb begin
      tap_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tap_data = tap_data | tap_w[i];
      end
   end

endmodule

>>> rtl/bounded_deque_with_middle_core.sv
// Bounded double-ended queue of signed 32-bit words with a middle-entry readout.
// Depends on bdm_pkg, bdm_cell_row and bounded_deque_with_middle_core_defines.svh.
//
// Each word taken on start (while busy is low) is one operation: push front,
// push back, pop front or pop back. Exactly one result word follows for every
// operation, shown for a single cycle with rsp_valid high and registered from the
// busy state; the receiver cannot stall it, so it must capture the result in
// that cycle. The block cannot take a new operation while busy, which is
// high in the state that an accept enters. The queue lives in a chain of DEPTH
// cells with the front at cell zero; pushes and pops at the front shift the
// whole chain by one place in the accept cycle, and pushes at the back write the
// cell just past the last entry. One shared tap bus reads the chain: in the
// accept cycle it reads the word being popped, and in the busy cycle it reads
// the entry at floor(length / 2) of the updated queue. That second read of the
// same bus is what keeps the block busy. A push on a full queue is dropped and
// reports status full, a pop on an empty queue reports status empty, and in both
// cases the queue is left unchanged. Popped value is zero unless a pop succeeded,
// and middle value is zero while the queue is empty.
`include "bounded_deque_with_middle_core_defines.svh"

module bounded_deque_with_middle_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic signed [bdm_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [bdm_pkg::DATA_W-1:0] rsp_popped_value,
   output logic [bdm_pkg::LEN_W-1:0]         rsp_length,
   output logic                              rsp_middle_valid,
   output logic signed [bdm_pkg::DATA_W-1:0] rsp_middle_value
);
   import bdm_pkg::*;

   // Control state.
   fsm_type          state_ff, state_in;
   logic [LEN_W-1:0] len_ff,   len_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-operation payload carried from the accept cycle into the busy cycle.
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] popped_ff, popped_in;

   // Registered result word.
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_popped_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic              rsp_mid_valid_ff;
   logic [DATA_W-1:0] rsp_mid_value_ff;

   logic              accept;
   logic              in_mid;
   func_type          func;
   logic              is_push;
   logic              op_ok;
   status_type        op_status;
   logic [LEN_W-1:0]  len_minus_one;
   logic [LEN_W-1:0]  len_half;
   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] tap_data;

   assign func          = func_type'(req_func);
   assign is_push       = (func == OP_PUSH_FRONT) || (func == OP_PUSH_BACK);
   assign len_minus_one = len_ff - LEN_W'(1);
   assign len_half      = len_ff >> 1;

   // Next state.
   always_comb begin
      unique case (state_ff)
         FSM_IDLE: state_in = (start) ? FSM_MID : FSM_IDLE;
         FSM_MID:  state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      unique case (state_ff)
         FSM_IDLE: begin
            busy   = 1'b0;
            accept = start;
            in_mid = 1'b0;
         end
         FSM_MID: begin
            busy   = 1'b1;
            accept = 1'b0;
            in_mid = 1'b1;
         end
         default: begin
            busy   = 1'b0;
            accept = 1'b0;
            in_mid = 1'b0;
         end
      endcase
   end

   // Decide the status of the incoming operation from the current fill level.
   always_comb begin
      priority if (is_push && (len_ff == LEN_W'(DEPTH))) begin
         op_status = ST_FULL;
      end else if (!is_push && (len_ff == '0)) begin
         op_status = ST_EMPTY;
      end else begin
         op_status = ST_OK;
      end
   end

   assign op_ok = accept && (op_status == ST_OK);

   // Cell chain control. The tap selects the back entry for a pop at the back,
   // cell zero otherwise, and the middle entry during the busy cycle.
   always_comb begin
      ctrl.shift_right = op_ok && (func == OP_PUSH_FRONT);
      ctrl.shift_left  = op_ok && (func == OP_POP_FRONT);
      ctrl.write_back  = op_ok && (func == OP_PUSH_BACK);
      ctrl.back_idx    = len_ff[IDX_W-1:0];
      if (in_mid) begin
         ctrl.sel_idx = len_half[IDX_W-1:0];
      end else if (func == OP_POP_BACK) begin
         ctrl.sel_idx = len_minus_one[IDX_W-1:0];
      end else begin
         ctrl.sel_idx = '0;
      end
   end

   bdm_cell_row u_row (
      .clock    (clock),
      .ctrl     (ctrl),
      .value    (req_value),
      .tap_data (tap_data)
   );

   // Length and per-operation payload for the busy cycle.
   always_comb begin
      len_in    = len_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      if (accept) begin
         status_in = op_status;
         popped_in = '0;
         if (op_ok) begin
            if (is_push) begin
               len_in = len_ff + LEN_W'(1);
            end else begin
               len_in    = len_minus_one;
               popped_in = tap_data;
            end
         end
      end
   end

   assign rsp_valid_in = in_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (in_mid) begin
         rsp_status_ff    <= status_ff;
         rsp_popped_ff    <= popped_ff;
         rsp_length_ff    <= len_ff;
         rsp_mid_valid_ff <= (len_ff != '0);
         rsp_mid_value_ff <= (len_ff != '0) ? tap_data : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_length       = rsp_length_ff;
   assign rsp_middle_valid = rsp_mid_valid_ff;
   assign rsp_middle_value = rsp_mid_value_ff;

   // The fill level never passes the number of cells.
   `BDM_ASSERT_IMPLIES(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(DEPTH))
   // Every accepted word is followed by the busy state and then a result.
   `BDM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `BDM_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy)
   // A dropped push can only be reported with a full queue.
   `BDM_ASSERT_IMPLIES(a_full_len, clock, reset,
      rsp_valid && (rsp_status == ST_FULL), rsp_length == LEN_W'(DEPTH))
   // The middle flag tracks an empty queue, and an empty queue shows zero.
   `BDM_ASSERT_IMPLIES(a_mid_empty, clock, reset,
      rsp_valid && !rsp_middle_valid, (rsp_length == '0) && (rsp_middle_value == '0))

endmodule
